[rtl/tkh_pkg.sv]
// Shared types and constants for the top-K min-heap selector.
package tkh_pkg;

	// Fill count and K are 7 bits wide (0..127)
	localparam int CNT_W = 7;

	// Input mode codes
	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_DUMP = 1'b1;

	// Reset value of the K register
	localparam logic [CNT_W-1:0] K_RESET = 7'd10;

	// Request from the control FSM to the heap engine
	typedef struct packed {
		logic             heapify;    // sift every node from count/2 down to root
		logic             sift_root;  // place a new root value and sift it down
		logic [CNT_W-1:0] count;      // number of valid heap entries
	} tkh_req_t;

endpackage

[rtl/tkh_ram.sv]
// Generic simple dual-port RAM with registered read data.
module tkh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds its data while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[rtl/tkh_heap.sv]
// Heap store and sift-down engine with one shared signed comparator.
module tkh_heap #(
	parameter int HEAP_SIZE  = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  tkh_pkg::tkh_req_t                             req,
	input  logic [VALUE_BITS-1:0]                         root_val,
	input  logic                                          host_we,
	input  logic                                          host_re,
	input  logic [(HEAP_SIZE > 1 ? $clog2(HEAP_SIZE) : 1)-1:0] host_addr,
	input  logic [VALUE_BITS-1:0]                         host_wdata,
	output logic                                          busy,
	output logic [VALUE_BITS-1:0]                         rdata
);

	import tkh_pkg::*;

	localparam int AW = (HEAP_SIZE > 1) ? $clog2(HEAP_SIZE) : 1;
	localparam int IW = CNT_W + 1;

	// Engine states
	localparam logic [2:0] E_IDLE    = 3'd0;
	localparam logic [2:0] E_RD_NODE = 3'd1;
	localparam logic [2:0] E_GET     = 3'd2;
	localparam logic [2:0] E_CHK     = 3'd3;
	localparam logic [2:0] E_GETL    = 3'd4;
	localparam logic [2:0] E_SEL     = 3'd5;
	localparam logic [2:0] E_CMP     = 3'd6;
	localparam logic [2:0] E_PUT     = 3'd7;

	logic [2:0]            state_q;
	logic [CNT_W-1:0]      count_q;
	logic                  heapify_q;
	logic [AW-1:0]         i_q;
	logic [AW-1:0]         node_q;
	logic [AW-1:0]         c_q;
	logic [VALUE_BITS-1:0] cur_q;
	logic [VALUE_BITS-1:0] cv_q;

	logic [IW-1:0]         left_w;
	logic [IW-1:0]         right_w;
	logic [IW-1:0]         cnt_w;
	logic                  has_left;
	logic                  has_right;

	logic [VALUE_BITS-1:0] cmp_a;
	logic [VALUE_BITS-1:0] cmp_b;
	logic                  cmp_lt;

	logic                  e_we;
	logic                  e_re;
	logic [AW-1:0]         e_waddr;
	logic [AW-1:0]         e_raddr;
	logic [VALUE_BITS-1:0] e_wdata;

	logic                  ram_we;
	logic                  ram_re;
	logic [AW-1:0]         ram_waddr;
	logic [AW-1:0]         ram_raddr;
	logic [VALUE_BITS-1:0] ram_wdata;

	assign busy = (state_q != E_IDLE);

	// Child indices of the current node
	assign left_w    = (IW'(node_q) << 1) + IW'(1);
	assign right_w   = left_w + IW'(1);
	assign cnt_w     = IW'(count_q);
	assign has_left  = (left_w < cnt_w);
	assign has_right = (right_w < cnt_w);

	// Shared comparator: right vs left child in E_SEL, chosen child vs sifted value otherwise
	assign cmp_a  = (state_q == E_SEL) ? rdata : cv_q;
	assign cmp_b  = (state_q == E_SEL) ? cv_q : cur_q;
	assign cmp_lt = ($signed(cmp_a) < $signed(cmp_b));

	// Engine memory accesses
	always_comb begin
		e_we    = 1'b0;
		e_re    = 1'b0;
		e_waddr = node_q;
		e_raddr = node_q;
		e_wdata = cur_q;
		case (state_q)
			E_RD_NODE: begin
				e_re = 1'b1;
			end
			E_CHK: begin
				e_re    = has_left;
				e_raddr = left_w[AW-1:0];
			end
			E_GETL: begin
				e_re    = has_right;
				e_raddr = right_w[AW-1:0];
			end
			E_CMP: begin
				e_we    = cmp_lt;
				e_wdata = cv_q;
			end
			E_PUT: begin
				e_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Host owns the memory port while the engine is idle
	assign ram_we    = busy ? e_we    : host_we;
	assign ram_re    = busy ? e_re    : host_re;
	assign ram_waddr = busy ? e_waddr : host_addr;
	assign ram_raddr = busy ? e_raddr : host_addr;
	assign ram_wdata = busy ? e_wdata : host_wdata;

	tkh_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (HEAP_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rdata)
	);

	// Sift-down sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			case (state_q)
				E_IDLE: begin
					if (req.heapify) begin
						count_q   <= req.count;
						heapify_q <= 1'b1;
						i_q       <= AW'(req.count >> 1);
						node_q    <= AW'(req.count >> 1);
						state_q   <= E_RD_NODE;
					end else if (req.sift_root) begin
						count_q   <= req.count;
						heapify_q <= 1'b0;
						node_q    <= '0;
						cur_q     <= root_val;
						state_q   <= E_CHK;
					end
				end
				E_RD_NODE: begin
					state_q <= E_GET;
				end
				E_GET: begin
					cur_q   <= rdata;
					state_q <= E_CHK;
				end
				E_CHK: begin
					state_q <= has_left ? E_GETL : E_PUT;
				end
				E_GETL: begin
					cv_q    <= rdata;
					c_q     <= left_w[AW-1:0];
					state_q <= has_right ? E_SEL : E_CMP;
				end
				E_SEL: begin
					if (cmp_lt) begin
						cv_q <= rdata;
						c_q  <= right_w[AW-1:0];
					end
					state_q <= E_CMP;
				end
				E_CMP: begin
					// smaller child moves up, sifted value continues down
					if (cmp_lt) begin
						node_q  <= c_q;
						state_q <= E_CHK;
					end else begin
						state_q <= E_PUT;
					end
				end
				E_PUT: begin
					if (heapify_q && (i_q != '0)) begin
						i_q     <= i_q - AW'(1);
						node_q  <= i_q - AW'(1);
						state_q <= E_RD_NODE;
					end else begin
						state_q <= E_IDLE;
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/top_k_min_heap_select.sv]
// Top level of the top-K selector: control sequencer, config register, output register.
//
// Keeps the K largest signed values of a stream in a min-heap of HEAP_SIZE entries.
// Input channel (in_valid/in_stall): mode 0 pushes value, mode 1 dumps the store.
// Output channel (out_valid/out_stall): one result per push; one result per stored
// entry on a dump (array order), last marks the final one; an empty dump gives a
// single result with dump_valid low.
// K is written through cfg_wr_en/cfg_wr_data; the user must write it only while the
// block is idle, as the block itself does not enforce this. Values of 0 act as 1 and
// values above HEAP_SIZE act as HEAP_SIZE. One transaction is worked on at a time;
// in_stall stays high until its results are all loaded into the output register.
// Heapifying, done when the store fills or before a push to a full store or a dump
// of a non-empty store not yet in heap order, sifts each node from count/2 down to
// the root. The work is serialised by the single read port of the heap memory and
// the one comparator of the sift engine.
// A stalled receiver holds the output register; the sequencer waits for it.
// Reset clears the fill count and the heap order flag and sets K to 10. The heap
// memory is not cleared; only entries below the fill count are ever read.
module top_k_min_heap_select #(
	parameter int HEAP_SIZE  = 16,
	parameter int VALUE_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [tkh_pkg::CNT_W-1:0] cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic signed [31:0]        value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      kept,
	output logic                      dropped_valid,
	output logic signed [31:0]        dropped_value,
	output logic signed [31:0]        heap_min,
	output logic [tkh_pkg::CNT_W-1:0] fill_count,
	output logic                      dump_valid,
	output logic signed [31:0]        dump_value,
	output logic                      last
);

	import tkh_pkg::*;

	localparam int AW = (HEAP_SIZE > 1) ? $clog2(HEAP_SIZE) : 1;

	// Control states
	localparam logic [3:0] T_IDLE     = 4'd0;
	localparam logic [3:0] T_FILL     = 4'd1;
	localparam logic [3:0] T_ORDER    = 4'd2;
	localparam logic [3:0] T_RD_ROOT  = 4'd3;
	localparam logic [3:0] T_ROOT     = 4'd4;
	localparam logic [3:0] T_RD_MIN   = 4'd5;
	localparam logic [3:0] T_MIN      = 4'd6;
	localparam logic [3:0] T_EMIT     = 4'd7;
	localparam logic [3:0] T_DUMP_RD  = 4'd8;
	localparam logic [3:0] T_DUMP_OUT = 4'd9;

	logic [3:0]            state_q;
	logic [CNT_W-1:0]      k_active_q;
	logic [CNT_W-1:0]      count_q;
	logic                  ordered_q;
	logic                  mode_q;
	logic                  after_root_q;
	logic [VALUE_BITS-1:0] v_q;
	logic [AW-1:0]         idx_q;
	logic                  res_kept_q;
	logic                  res_dv_q;
	logic [31:0]           res_dval_q;
	logic [31:0]           min_q;

	logic                  out_valid_q;
	logic                  out_kept_q;
	logic                  out_dv_q;
	logic [31:0]           out_dval_q;
	logic [31:0]           out_min_q;
	logic [CNT_W-1:0]      out_fill_q;
	logic                  out_dump_valid_q;
	logic [31:0]           out_dump_value_q;
	logic                  out_last_q;

	logic [CNT_W-1:0]      k_eff;
	logic                  in_acc;
	logic                  full;
	logic                  fill_done;
	logic                  out_free;
	logic                  root_lt;
	logic                  dump_last;
	logic [63:0]           in64;
	logic [VALUE_BITS-1:0] v_word;
	logic [63:0]           rd64;
	logic [63:0]           v64;
	logic [31:0]           rd32;
	logic [31:0]           v32;

	tkh_req_t              req;
	logic                  host_we;
	logic                  host_re;
	logic [AW-1:0]         host_addr;
	logic                  eng_busy;
	logic [VALUE_BITS-1:0] eng_rdata;

	// Effective K, clamped to 1..HEAP_SIZE
	always_comb begin
		if (k_active_q == '0) begin
			k_eff = CNT_W'(1);
		end else if (k_active_q > CNT_W'(HEAP_SIZE)) begin
			k_eff = CNT_W'(HEAP_SIZE);
		end else begin
			k_eff = k_active_q;
		end
	end

	// Value width conversion in and out of the heap word
	assign in64   = {32'd0, value};
	assign v_word = in64[VALUE_BITS-1:0];
	assign rd64   = 64'(eng_rdata);
	assign v64    = 64'(v_q);
	assign rd32   = rd64[31:0];
	assign v32    = v64[31:0];

	assign in_stall  = (state_q != T_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign full      = (count_q >= k_eff);
	assign fill_done = ((count_q + CNT_W'(1)) >= k_eff);
	assign out_free  = !out_valid_q || !out_stall;
	assign root_lt   = ($signed(eng_rdata) < $signed(v_q));
	assign dump_last = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	// Engine requests and host memory accesses
	always_comb begin
		req       = '0;
		host_we   = 1'b0;
		host_re   = 1'b0;
		host_addr = '0;
		case (state_q)
			T_IDLE: begin
				if (in_acc && !ordered_q &&
				    (((mode == MODE_PUSH) && full) ||
				     ((mode == MODE_DUMP) && (count_q != '0)))) begin
					req.heapify = 1'b1;
					req.count   = count_q;
				end
			end
			T_FILL: begin
				host_we   = 1'b1;
				host_addr = AW'(count_q);
				if (fill_done) begin
					req.heapify = 1'b1;
					req.count   = count_q + CNT_W'(1);
				end
			end
			T_RD_ROOT, T_RD_MIN: begin
				host_re = 1'b1;
			end
			T_ROOT: begin
				if (root_lt) begin
					req.sift_root = 1'b1;
					req.count     = count_q;
				end
			end
			T_DUMP_RD: begin
				host_re   = 1'b1;
				host_addr = idx_q;
			end
			default: begin
			end
		endcase
	end

	tkh_heap #(
		.HEAP_SIZE  (HEAP_SIZE),
		.VALUE_BITS (VALUE_BITS)
	) u_heap (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.root_val   (v_q),
		.host_we    (host_we),
		.host_re    (host_re),
		.host_addr  (host_addr),
		.host_wdata (v_q),
		.busy       (eng_busy),
		.rdata      (eng_rdata)
	);

	// Control sequencer and configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= T_IDLE;
			k_active_q <= K_RESET;
			count_q    <= '0;
			ordered_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				k_active_q <= cfg_wr_data;
			end
			case (state_q)
				T_IDLE: begin
					if (in_acc) begin
						mode_q       <= mode;
						v_q          <= v_word;
						res_kept_q   <= 1'b0;
						res_dv_q     <= 1'b0;
						res_dval_q   <= '0;
						after_root_q <= (mode == MODE_PUSH) && full;
						if (mode == MODE_PUSH) begin
							if (!full) begin
								state_q <= T_FILL;
							end else if (!ordered_q) begin
								ordered_q <= 1'b1;
								state_q   <= T_ORDER;
							end else begin
								state_q <= T_RD_ROOT;
							end
						end else begin
							if (count_q == '0) begin
								min_q   <= '0;
								state_q <= T_EMIT;
							end else if (!ordered_q) begin
								ordered_q <= 1'b1;
								state_q   <= T_ORDER;
							end else begin
								state_q <= T_RD_MIN;
							end
						end
					end
				end
				T_FILL: begin
					count_q    <= count_q + CNT_W'(1);
					res_kept_q <= 1'b1;
					if (fill_done) begin
						ordered_q <= 1'b1;
						state_q   <= T_ORDER;
					end else begin
						ordered_q <= 1'b0;
						state_q   <= T_RD_MIN;
					end
				end
				T_ORDER: begin
					if (!eng_busy) begin
						state_q <= after_root_q ? T_RD_ROOT : T_RD_MIN;
					end
				end
				T_RD_ROOT: begin
					state_q <= T_ROOT;
				end
				T_ROOT: begin
					// replace the root only when the new value is strictly larger
					res_dv_q <= 1'b1;
					if (root_lt) begin
						res_kept_q   <= 1'b1;
						res_dval_q   <= rd32;
						after_root_q <= 1'b0;
						state_q      <= T_ORDER;
					end else begin
						res_dval_q <= v32;
						state_q    <= T_RD_MIN;
					end
				end
				T_RD_MIN: begin
					state_q <= T_MIN;
				end
				T_MIN: begin
					min_q <= rd32;
					if (mode_q == MODE_PUSH) begin
						state_q <= T_EMIT;
					end else begin
						idx_q   <= '0;
						state_q <= T_DUMP_RD;
					end
				end
				T_EMIT: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				T_DUMP_RD: begin
					state_q <= T_DUMP_OUT;
				end
				T_DUMP_OUT: begin
					if (out_free) begin
						if (dump_last) begin
							state_q <= T_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= T_DUMP_RD;
						end
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free &&
		             ((state_q == T_EMIT) || (state_q == T_DUMP_OUT))) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_free && (state_q == T_EMIT)) begin
			out_kept_q       <= res_kept_q;
			out_dv_q         <= res_dv_q;
			out_dval_q       <= res_dval_q;
			out_min_q        <= min_q;
			out_fill_q       <= count_q;
			out_dump_valid_q <= 1'b0;
			out_dump_value_q <= '0;
			out_last_q       <= 1'b1;
		end else if (out_free && (state_q == T_DUMP_OUT)) begin
			out_kept_q       <= 1'b0;
			out_dv_q         <= 1'b0;
			out_dval_q       <= '0;
			out_min_q        <= min_q;
			out_fill_q       <= count_q;
			out_dump_valid_q <= 1'b1;
			out_dump_value_q <= rd32;
			out_last_q       <= dump_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kept          = out_kept_q;
	assign dropped_valid = out_dv_q;
	assign dropped_value = out_dval_q;
	assign heap_min      = out_min_q;
	assign fill_count    = out_fill_q;
	assign dump_valid    = out_dump_valid_q;
	assign dump_value    = out_dump_value_q;
	assign last          = out_last_q;

	// Fill count never passes the store depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HEAP_SIZE))
		else $error("fill count exceeds heap depth");

	// Sift engine only runs while a transaction is in progress
	a_engine_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_IDLE) |-> !eng_busy)
		else $error("heap engine busy while controller idle");

	// Root compare only happens on an ordered, non-empty heap while the engine is idle
	a_root_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_ROOT) |-> (ordered_q && !eng_busy && (count_q != '0)))
		else $error("root compared before heap ordered");

	// A dump read never goes past the fill count
	a_dump_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_DUMP_RD) |-> (CNT_W'(idx_q) < count_q))
		else $error("dump index beyond fill count");

endmodule

[test/testbench.sv]
// Self-checking testbench for the top-K min-heap selector: random handshakes, built-in heap predictor.
module testbench;
	import tkh_pkg::*;

	localparam int HEAP_SIZE    = 16;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int IDLE_GUARD   = 8;
	localparam int TAIL_CYCLES  = 60;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {STEP_ITEM, STEP_K_WRITE, STEP_DRAIN} step_kind_t;

	typedef struct {
		step_kind_t         kind;
		logic               mode;
		logic signed [31:0] value;
		logic [CNT_W-1:0]   k;
	} stim_step_t;

	typedef struct {
		logic               kept;
		logic               drop_v;
		logic signed [31:0] drop_val;
		logic signed [31:0] hmin;
		logic [CNT_W-1:0]   fill;
		logic               dmp_v;
		logic signed [31:0] dmp_val;
		logic               lst;
	} sel_result_t;

	logic                     clk;
	logic                     arst_n      = 1'b0;
	logic                     cfg_wr_en   = 1'b0;
	logic [CNT_W-1:0]         cfg_wr_data = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_stall;
	logic                     mode        = MODE_PUSH;
	logic signed [31:0]       value       = '0;
	logic                     out_valid;
	logic                     out_stall   = 1'b0;
	logic                     kept;
	logic                     dropped_valid;
	logic signed [31:0]       dropped_value;
	logic signed [31:0]       heap_min;
	logic [CNT_W-1:0]         fill_count;
	logic                     dump_valid;
	logic signed [31:0]       dump_value;
	logic                     last;

	top_k_min_heap_select uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kept          (kept),
		.dropped_valid (dropped_valid),
		.dropped_value (dropped_value),
		.heap_min      (heap_min),
		.fill_count    (fill_count),
		.dump_valid    (dump_valid),
		.dump_value    (dump_value),
		.last          (last)
	);

	// Heap predictor state
	logic signed [31:0] heap_mdl [HEAP_SIZE];
	int unsigned        fill_mdl    = 0;
	bit                 ordered_mdl = 1'b0;
	logic [CNT_W-1:0]   k_mdl       = K_RESET;

	sel_result_t result_q [$];
	stim_step_t  stim_q [$];

	int gap_left    = 0;
	int in_burst    = 0;
	int idle_cycles = 0;
	int issued      = 0;
	int checked     = 0;
	int stall_left  = 0;
	int out_burst   = 0;
	int mismatches  = 0;
	int cycle_cnt   = 0;

	// Effective K: zero acts as one, anything above the depth acts as the depth
	function automatic int unsigned k_limit();
		if (k_mdl < 1)
			return 1;
		if (k_mdl > HEAP_SIZE)
			return HEAP_SIZE;
		return 32'(k_mdl);
	endfunction

	function automatic void sift_down_mdl(int unsigned node, int unsigned cnt);
		int unsigned        c;
		logic signed [31:0] t;
		while (2 * node + 1 < cnt) begin
			c = 2 * node + 1;
			if (c + 1 < cnt && heap_mdl[c + 1] < heap_mdl[c])
				c++;
			if (!(heap_mdl[c] < heap_mdl[node]))
				break;
			t = heap_mdl[node];
			heap_mdl[node] = heap_mdl[c];
			heap_mdl[c] = t;
			node = c;
		end
	endfunction

	function automatic void heapify_mdl();
		for (int i = fill_mdl / 2; i >= 0; i--)
			sift_down_mdl(i, fill_mdl);
		ordered_mdl = 1'b1;
	endfunction

	// Update the heap for one accepted transaction, queue its results, return their number
	function automatic int predict_selection(logic m, logic signed [31:0] v);
		sel_result_t r;
		r = '{default: '0};
		if (m == MODE_PUSH) begin
			if (fill_mdl < k_limit()) begin
				heap_mdl[fill_mdl] = v;
				fill_mdl++;
				ordered_mdl = 1'b0;
				if (fill_mdl >= k_limit())
					heapify_mdl();
				r.kept = 1'b1;
			end else begin
				if (!ordered_mdl)
					heapify_mdl();
				r.drop_v = 1'b1;
				if (heap_mdl[0] < v) begin
					r.drop_val = heap_mdl[0];
					heap_mdl[0] = v;
					sift_down_mdl(0, fill_mdl);
					r.kept = 1'b1;
				end else begin
					r.drop_val = v;
				end
			end
			r.hmin = heap_mdl[0];
			r.fill = CNT_W'(fill_mdl);
			r.lst  = 1'b1;
			result_q.push_back(r);
			return 1;
		end
		// empty dump: a single marker result
		if (fill_mdl == 0) begin
			r.lst = 1'b1;
			result_q.push_back(r);
			return 1;
		end
		if (!ordered_mdl)
			heapify_mdl();
		for (int i = 0; i < fill_mdl; i++) begin
			r.hmin    = heap_mdl[0];
			r.fill    = CNT_W'(fill_mdl);
			r.dmp_v   = 1'b1;
			r.dmp_val = heap_mdl[i];
			r.lst     = (i + 1 == fill_mdl);
			result_q.push_back(r);
		end
		return fill_mdl;
	endfunction

	// Gap length: mostly short, a few long, now and then a run with none
	function automatic int pick_gap(inout int burst);
		int roll;
		if (burst > 0) begin
			burst--;
			return 0;
		end
		roll = $urandom_range(99);
		if (roll < 3) begin
			burst = $urandom_range(40, 15);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(3, 1);
		if (roll < 97)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(9))
			0: return VAL_MAX;
			1: return VAL_MIN;
			2, 3, 4: return $urandom_range(100) - 50;
			default: return $urandom();
		endcase
	endfunction

	function automatic void add_item(logic m, logic signed [31:0] v);
		stim_step_t s;
		s = '{kind: STEP_ITEM, mode: m, value: v, k: '0};
		stim_q.push_back(s);
	endfunction

	function automatic void add_k(logic [CNT_W-1:0] k);
		stim_step_t s;
		s = '{kind: STEP_K_WRITE, mode: MODE_PUSH, value: '0, k: k};
		stim_q.push_back(s);
	endfunction

	function automatic void add_drain();
		stim_step_t s;
		s = '{kind: STEP_DRAIN, mode: MODE_PUSH, value: '0, k: '0};
		stim_q.push_back(s);
	endfunction

	function automatic void check_field(string name, logic signed [63:0] want,
		logic signed [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Input driver: launches queued transactions, K writes only when the block is idle
	always @(posedge clk) begin
		logic       valid_nx;
		logic       wr_nx;
		stim_step_t head;
		if (arst_n) begin
			valid_nx = in_valid;
			wr_nx    = 1'b0;
			if (in_valid && !in_stall) begin
				issued += predict_selection(mode, value);
				valid_nx = 1'b0;
			end
			if (issued == checked)
				idle_cycles++;
			else
				idle_cycles = 0;
			if (!valid_nx && gap_left > 0) begin
				gap_left--;
			end else if (!valid_nx && stim_q.size() > 0) begin
				head = stim_q[0];
				case (head.kind)
					STEP_ITEM: begin
						void'(stim_q.pop_front());
						mode     <= head.mode;
						value    <= head.value;
						valid_nx = 1'b1;
						gap_left = pick_gap(in_burst);
					end
					STEP_K_WRITE: begin
						if (idle_cycles >= IDLE_GUARD) begin
							void'(stim_q.pop_front());
							cfg_wr_data <= head.k;
							wr_nx = 1'b1;
							k_mdl = head.k;
						end
					end
					default: begin
						// hold off until every result is back
						if (idle_cycles >= IDLE_GUARD)
							void'(stim_q.pop_front());
					end
				endcase
			end
			in_valid  <= valid_nx;
			cfg_wr_en <= wr_nx;
		end
	end

	// Output monitor: checks each accepted result, drives random stalls
	always @(posedge clk) begin
		sel_result_t want;
		logic        stall_nx;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual dump_valid %0d value %0d",
						$time, dump_valid, dump_value);
					mismatches++;
				end else begin
					want = result_q.pop_front();
					check_field("kept", want.kept, kept);
					check_field("dropped_valid", want.drop_v, dropped_valid);
					check_field("dropped_value", want.drop_val, dropped_value);
					check_field("heap_min", want.hmin, heap_min);
					check_field("fill_count", want.fill, fill_count);
					check_field("dump_valid", want.dmp_v, dump_valid);
					check_field("dump_value", want.dmp_val, dump_value);
					check_field("last", want.lst, last);
					checked <= checked + 1;
				end
			end
			stall_nx = 1'b0;
			if (stall_left > 0) begin
				stall_left--;
				stall_nx = 1'b1;
			end else if ($urandom_range(99) < 30) begin
				stall_left = pick_gap(out_burst);
			end
			out_stall <= stall_nx;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d results outstanding", $time, result_q.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Stimulus, reset and end of run
	initial begin
		logic [CNT_W-1:0] ks [8];

		// directed: empty dump, extremes during fill, partial dump
		add_item(MODE_DUMP, 32'sh5A5A_5A5A);
		add_item(MODE_PUSH, VAL_MAX);
		add_item(MODE_PUSH, VAL_MIN);
		add_item(MODE_PUSH, 0);
		add_item(MODE_PUSH, -1);
		add_item(MODE_PUSH, 1);
		add_item(MODE_PUSH, 100);
		add_item(MODE_PUSH, -100);
		add_item(MODE_DUMP, 32'sh0F0F_0F0F);
		// reach the reset K, which heapifies
		add_item(MODE_PUSH, 42);
		add_item(MODE_PUSH, -7);
		add_item(MODE_PUSH, 3);
		// equal to root, then replace, then equal and smaller
		add_item(MODE_PUSH, VAL_MIN);
		add_item(MODE_PUSH, 5);
		add_item(MODE_PUSH, -100);
		add_item(MODE_PUSH, -500);
		add_item(MODE_DUMP, 0);
		// K lowered below the fill count
		add_k(7'd4);
		add_item(MODE_PUSH, 7);
		add_item(MODE_PUSH, VAL_MIN);
		add_item(MODE_DUMP, -1);
		// K above the depth: fill resumes
		add_k(7'd127);
		add_item(MODE_PUSH, VAL_MAX);
		add_item(MODE_PUSH, 9);
		add_item(MODE_DUMP, VAL_MAX);

		// random phases over several K settings
		ks = '{7'd12, 7'd0, 7'd14, 7'd1, 7'd16, 7'd127, 7'd6, 7'd10};
		ks[7] = CNT_W'($urandom_range(127, 2));
		foreach (ks[p]) begin
			add_k(ks[p]);
			for (int n = 0; n < 24; n++) begin
				if (n == 12 && p % 3 == 1)
					add_drain();
				if ($urandom_range(11) == 0)
					add_item(MODE_DUMP, $urandom());
				else
					add_item(MODE_PUSH, pick_value());
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() > 0 || in_valid || issued != checked)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		if (result_q.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, result_q.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
